// ===== src/stq_pkg.sv =====
// Shared types and codes for the sorted task ready queue.
`default_nettype none

package stq_pkg;

   localparam int ID_W    = 4;
   localparam int KEY_W   = 32;
   localparam int ENTRY_W = ID_W + KEY_W;
   localparam int CNT_OUT_W = 5;
   localparam int STAT_W  = 3;
   localparam int KIND_W  = 2;

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key_a;
      logic [KEY_W-1:0] key_b;
      logic [ID_W-1:0]  id_a;
      logic [ID_W-1:0]  id_b;
      logic             low_first;
   } cmp_req_type;

   typedef struct packed {
      logic better;   // key_a strictly ahead of key_b
      logic id_hit;
   } cmp_rsp_type;

endpackage

`default_nettype wire

// ===== src/sorted_task_ready_queue_core.sv =====
// Sorted task ready queue: top level with the operation sequencer.
`default_nettype none

// Keeps up to MAX_TASKS task ids in key order in one single-port-read RAM; slot 0
// is the head. order_mode (csr_wdata) 0 puts higher keys first, 1 lower keys first;
// stored entries are not re-sorted when it changes. One transaction is worked on at
// a time. Insert and delete scan the n queued entries, then move entries one per
// cycle to open or close the gap; extract reads only the head, then moves n - 1
// entries. Duplicate and not-found errors return after the scan; full, empty and
// an unused kind go straight to the result. The RAM's one read per cycle sets the
// pace of scan and moves. A finished result waits in the output register while
// the next request is accepted.
module sorted_task_ready_queue_core
   import stq_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,      // order_mode
   // requests
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,      // [3:0] task_id, [35:4] sort_key, rest zero
   input  wire logic [1:0]  req_tuser,      // [1:0] kind
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata       // [3:0] out_task_id, [6:4] status,
                                            // [11:7] entry_count, rest zero
);

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TASKS);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // control
   logic [2:0]        state_ff, state_in;
   logic [CW-1:0]     occ_ff, occ_in;
   logic              mode_ff, mode_in;
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic [CW-1:0]     scan_lim_ff, scan_lim_in;
   logic              chk_vld_ff, chk_vld_in;
   logic              found_ff, found_in;
   logic              dup_ff, dup_in;
   logic [CW-1:0]     sh_cnt_ff, sh_cnt_in;
   logic              wr_pend_ff, wr_pend_in;
   logic              rsp_vld_ff, rsp_vld_in;
   // payload
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IW-1:0]     chk_idx_ff, chk_idx_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [IW-1:0]     sh_src_ff, sh_src_in;
   logic [IW-1:0]     wr_addr_ff, wr_addr_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [15:0]       rsp_data_ff, rsp_data_in;

   // RAM and comparator
   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [ID_W-1:0]    rd_id;
   logic [KEY_W-1:0]   rd_key;
   cmp_req_type        cmp_req;
   cmp_rsp_type        cmp_rsp;

   logic              is_ins;
   logic [CW-1:0]     pos_fin;
   logic              accept;

   stq_ram #(
      .DEPTH (MAX_TASKS),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   stq_cmp u_cmp (
      .req (cmp_req),
      .rsp (cmp_rsp)
   );

   assign rd_id   = ram_rdata[ID_W-1:0];
   assign rd_key  = ram_rdata[ENTRY_W-1:ID_W];
   assign is_ins  = (kind_ff == KIND_INSERT);
   assign pos_fin = found_ff ? pos_ff : occ_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // on insert, head slot compares new key against stored; otherwise stored against new
   always_comb begin
      cmp_req.low_first = mode_ff;
      cmp_req.id_a      = id_ff;
      cmp_req.id_b      = rd_id;
      if (is_ins && (chk_idx_ff == '0)) begin
         cmp_req.key_a = key_ff;
         cmp_req.key_b = rd_key;
      end else begin
         cmp_req.key_a = rd_key;
         cmp_req.key_b = key_ff;
      end
   end

   // RAM write: pending moved entry, or the new entry in S_PUT
   always_comb begin
      if (state_ff == S_PUT) begin
         ram_we    = 1'b1;
         ram_waddr = pos_ff[IW-1:0];
         ram_wdata = {key_ff, id_ff};
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end
   end

   always_comb begin
      state_in    = state_ff;
      occ_in      = occ_ff;
      mode_in     = csr_we ? csr_wdata : mode_ff;
      scan_idx_in = scan_idx_ff;
      scan_lim_in = scan_lim_ff;
      chk_vld_in  = 1'b0;
      found_in    = found_ff;
      dup_in      = dup_ff;
      sh_cnt_in   = sh_cnt_ff;
      wr_pend_in  = 1'b0;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      kind_in     = kind_ff;
      id_in       = id_ff;
      key_in      = key_ff;
      chk_idx_in  = chk_idx_ff;
      pos_in      = pos_ff;
      sh_src_in   = sh_src_ff;
      wr_addr_in  = wr_addr_ff;
      out_id_in   = out_id_ff;
      status_in   = status_ff;
      rsp_data_in = rsp_data_ff;
      ram_raddr   = '0;

      // comparison of the entry read last cycle
      if (chk_vld_ff) begin
         case (kind_ff)
            KIND_INSERT: begin
               if (cmp_rsp.id_hit) begin
                  dup_in = 1'b1;
               end
               if (!found_ff) begin
                  if (chk_idx_ff == '0) begin
                     if (cmp_rsp.better) begin
                        found_in = 1'b1;
                        pos_in   = '0;
                     end
                  end else if (!cmp_rsp.better) begin
                     found_in = 1'b1;
                     pos_in   = CW'(chk_idx_ff);
                  end
               end
            end
            KIND_EXTRACT: begin
               found_in  = 1'b1;
               pos_in    = '0;
               out_id_in = rd_id;
            end
            default: begin
               if (cmp_rsp.id_hit && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = CW'(chk_idx_ff);
               end
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in     = req_tuser;
               id_in       = req_tdata[ID_W-1:0];
               key_in      = req_tdata[ENTRY_W-1:ID_W];
               out_id_in   = '0;
               status_in   = ST_OK;
               scan_idx_in = '0;
               found_in    = 1'b0;
               dup_in      = 1'b0;
               case (req_tuser)
                  KIND_INSERT: begin
                     if (occ_ff >= MAX_CNT) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        scan_lim_in = occ_ff;
                        state_in    = S_SCAN;
                     end
                  end
                  KIND_EXTRACT: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        scan_lim_in = ONE_CNT;
                        state_in    = S_SCAN;
                     end
                  end
                  KIND_DELETE: begin
                     scan_lim_in = occ_ff;
                     state_in    = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (scan_idx_ff != scan_lim_ff) begin
               ram_raddr   = scan_idx_ff[IW-1:0];
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_idx_ff[IW-1:0];
               scan_idx_in = scan_idx_ff + ONE_CNT;
            end else if (!chk_vld_ff) begin
               if (is_ins) begin
                  if (dup_ff) begin
                     status_in = ST_DUPLICATE;
                     state_in  = S_DONE;
                  end else begin
                     pos_in    = pos_fin;
                     sh_cnt_in = occ_ff - pos_fin;
                     sh_src_in = IW'(occ_ff - ONE_CNT);
                     state_in  = S_SHIFT;
                  end
               end else if (!found_ff) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  sh_cnt_in = occ_ff - ONE_CNT - pos_ff;
                  sh_src_in = IW'(pos_ff + ONE_CNT);
                  state_in  = S_SHIFT;
               end
            end
         end

         // insert moves entries up from the tail; removal moves them down
         S_SHIFT: begin
            if (sh_cnt_ff != '0) begin
               ram_raddr  = sh_src_ff;
               wr_pend_in = 1'b1;
               sh_cnt_in  = sh_cnt_ff - ONE_CNT;
               if (is_ins) begin
                  wr_addr_in = sh_src_ff + IW'(1);
                  sh_src_in  = sh_src_ff - IW'(1);
               end else begin
                  wr_addr_in = sh_src_ff - IW'(1);
                  sh_src_in  = sh_src_ff + IW'(1);
               end
            end else if (!wr_pend_ff) begin
               if (is_ins) begin
                  state_in = S_PUT;
               end else begin
                  occ_in   = occ_ff - ONE_CNT;
                  state_in = S_DONE;
               end
            end
         end

         S_PUT: begin
            occ_in   = occ_ff + ONE_CNT;
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {4'b0000, CNT_OUT_W'(occ_ff), status_ff, out_id_ff};
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         occ_ff      <= '0;
         mode_ff     <= 1'b0;
         scan_idx_ff <= '0;
         scan_lim_ff <= '0;
         chk_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         dup_ff      <= 1'b0;
         sh_cnt_ff   <= '0;
         wr_pend_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         occ_ff      <= occ_in;
         mode_ff     <= mode_in;
         scan_idx_ff <= scan_idx_in;
         scan_lim_ff <= scan_lim_in;
         chk_vld_ff  <= chk_vld_in;
         found_ff    <= found_in;
         dup_ff      <= dup_in;
         sh_cnt_ff   <= sh_cnt_in;
         wr_pend_ff  <= wr_pend_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      key_ff      <= key_in;
      chk_idx_ff  <= chk_idx_in;
      pos_ff      <= pos_in;
      sh_src_ff   <= sh_src_in;
      wr_addr_ff  <= wr_addr_in;
      out_id_ff   <= out_id_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== src/stq_ram.sv =====
// Entry store: one write port, one registered read port.
`default_nettype none

module stq_ram
   import stq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/stq_cmp.sv =====
// Shared key and id comparator used by the scan sequencer.
`default_nettype none

module stq_cmp
   import stq_pkg::*;
(
   input  wire cmp_req_type req,
   output cmp_rsp_type      rsp
);

   always_comb begin
      rsp.better = req.low_first ? (req.key_a < req.key_b) : (req.key_a > req.key_b);
      rsp.id_hit = (req.id_a == req.id_b);
   end

endmodule

`default_nettype wire
